// File: src/png_unf_pkg.sv
// shared types, constants and predictor functions of the png scanline unfilter
`timescale 1ns / 1ps
package png_unf_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd2;

   // configuration reset values
   localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd1;
   localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd1;
   localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd3;

   // row filter codes
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // inserted opaque alpha
   localparam logic [7:0] ALPHA_BYTE = 8'hFF;

   // result queue depth
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // number of channel cells
   localparam int NUM_CELLS = 4;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_row;
      logic       end_of_image;
      logic       filter_error;
   } rsp_type;

   // neighbor bytes held by one channel cell
   typedef struct packed {
      logic [7:0] left;
      logic [7:0] ul;
   } nbr_type;

   // update strobes shared by all cells
   typedef struct packed {
      logic wr;
      logic clr;
   } cell_ctl_type;

   // paeth predictor on left a, above b, upper-left c
   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0] pa;
      logic [9:0] pb;
      logic [9:0] pc;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = da + db;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

   // average of left and above, rounded down
   function automatic logic [7:0] avg_pick(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

endpackage

// File: src/png_unf_cell.sv
// one channel cell: holds left and upper-left bytes of its channel, passes the selection on
`timescale 1ns / 1ps
module png_unf_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      sel,
   input  png_unf_pkg::cell_ctl_type ctl,
   input  logic [7:0]                recon,
   input  logic [7:0]                above,
   input  png_unf_pkg::nbr_type      chain_in,
   output png_unf_pkg::nbr_type      chain_out
);

   logic [7:0] left_ff;
   logic [7:0] left_in;
   logic [7:0] ul_ff;
   logic [7:0] ul_in;

   // row end clears, the selected cell takes the new bytes
   always_comb begin
      left_in = left_ff;
      ul_in   = ul_ff;
      if (ctl.clr) begin
         left_in = '0;
         ul_in   = '0;
      end else if (ctl.wr && sel) begin
         left_in = recon;
         ul_in   = above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         ul_ff   <= '0;
      end else begin
         left_ff <= left_in;
         ul_ff   <= ul_in;
      end
   end

   // selected cell puts its bytes on the chain, others pass the neighbor's
   always_comb begin
      if (sel) begin
         chain_out.left = left_ff;
         chain_out.ul   = ul_ff;
      end else begin
         chain_out = chain_in;
      end
   end

endmodule

// File: src/png_unf_outq.sv
// result queue: takes one or two items per push, gives one item per cycle while out_ready is high
`timescale 1ns / 1ps
module png_unf_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_en,
   input  logic                 push_two,
   input  png_unf_pkg::rsp_type push_first,
   input  png_unf_pkg::rsp_type push_second,
   output logic                 room,
   output logic                 out_valid,
   output png_unf_pkg::rsp_type out_item,
   input  logic                 out_ready
);

   localparam int PTR_W = png_unf_pkg::OQ_PTR_W;
   localparam int CNT_W = png_unf_pkg::OQ_CNT_W;

   png_unf_pkg::rsp_type q_ff [png_unf_pkg::OQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             pop;
   logic [CNT_W-1:0] n_push;

   assign room      = cnt_ff <= CNT_W'(png_unf_pkg::OQ_DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign out_item  = q_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // pointer and count bookkeeping
   always_comb begin
      n_push    = push_en ? (push_two ? CNT_W'(2) : CNT_W'(1)) : '0;
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + n_push - (pop ? CNT_W'(1) : CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_en) begin
         q_ff[wr_ptr_ff] <= push_first;
         if (push_two) begin
            q_ff[wr_ptr_ff + PTR_W'(1)] <= push_second;
         end
      end
   end

endmodule

// File: src/png_scanline_unfilter.sv
// top level of the png scanline unfilter
//
//   channel   dir  handshake              payload
//   req_      in   req_tvalid/req_tready  tdata: raw_byte
//   rsp_      out  rsp_tvalid/rsp_tready  tdata: out_byte, tlast: last_of_run,
//                                         tuser: end_of_row, end_of_image, filter_error
//   csr_      in   csr_we                 csr_index, csr_wdata
//
// One byte is taken per cycle while the stage register is empty or commits its item; its
// results pass through the stage register and the result queue to rsp_. The single result
// port sets the pace: three-channel images give four results per three bytes taken.
// Reset is synchronous and clears control state only; the line store is not cleared and
// needs no clearing pass.
// When rsp_tready is low a four-entry result queue fills, the stage register holds and
// req_tready falls.
`timescale 1ns / 1ps
module png_scanline_unfilter #(
   parameter int MAX_WIDTH  = png_unf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = png_unf_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser,   // [0] end_of_row, [1] end_of_image, [2] filter_error
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int STORE_DEPTH = MAX_WIDTH * 4;
   localparam int BYTE_W      = $clog2(STORE_DEPTH);
   localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int NC          = png_unf_pkg::NUM_CELLS;

   // configuration registers
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [2:0]  chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= png_unf_pkg::RST_IMAGE_WIDTH;
         height_ff <= png_unf_pkg::RST_IMAGE_HEIGHT;
         chan_ff   <= png_unf_pkg::RST_CHANNEL_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            png_unf_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[10:0];
            png_unf_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata;
            png_unf_pkg::CSR_CHANNEL_COUNT: chan_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // clamped configuration
   logic [10:0] eff_width;
   logic [12:0] eff_height;
   logic [2:0]  eff_chan;
   logic [13:0] row_bytes;

   always_comb begin
      priority if (width_ff == '0) begin
         eff_width = 11'd1;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = 11'(MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      priority if (height_ff == '0) begin
         eff_height = 13'd1;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_height = 13'(MAX_HEIGHT);
      end else begin
         eff_height = height_ff;
      end
      priority if (chan_ff == '0) begin
         eff_chan = 3'd1;
      end else if (chan_ff > 3'd4) begin
         eff_chan = 3'd4;
      end else begin
         eff_chan = chan_ff;
      end
      row_bytes = 14'(eff_width) * 14'(eff_chan);
   end

   // front state, updated when an item is taken while no filter error is latched
   logic              await_ff;
   logic              await_in;
   logic              error_latched_ff;
   logic              error_latched_in;
   logic [2:0]        filter_ff;
   logic [2:0]        filter_in;
   logic [BYTE_W-1:0] byte_in_row_ff;
   logic [BYTE_W-1:0] byte_in_row_in;
   logic [1:0]        mod3_ff;
   logic [1:0]        mod3_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;

   // stage register
   logic              a_valid_ff;
   logic              a_valid_in;
   logic              a_err_ff;
   logic [7:0]        a_raw_ff;
   logic [BYTE_W-1:0] a_idx_ff;
   logic [1:0]        a_k_ff;
   logic [2:0]        a_filter_ff;
   logic              a_row0_ff;
   logic              a_eor_ff;
   logic              a_eoi_ff;
   logic              a_alpha_ff;

   logic       accept;
   logic       commit;
   logic       commit_data;
   logic       oq_room;
   logic       load_err;
   logic       load_data;
   logic       bad_filter;
   logic [1:0] cur_k;
   logic       cur_eor;
   logic       cur_eoi;
   logic       cur_alpha;

   assign commit      = a_valid_ff && oq_room;
   assign commit_data = commit && !a_err_ff;
   assign req_tready  = !a_valid_ff || commit;
   assign accept      = req_tvalid && req_tready;
   assign bad_filter  = req_tdata > 8'(png_unf_pkg::FILT_PAETH);
   assign load_err    = accept && !error_latched_ff && await_ff && bad_filter;
   assign load_data   = accept && !error_latched_ff && !await_ff;

   // channel index and row position of the incoming byte
   always_comb begin
      unique case (eff_chan)
         3'd2:    cur_k = {1'b0, byte_in_row_ff[0]};
         3'd3:    cur_k = mod3_ff;
         3'd4:    cur_k = byte_in_row_ff[1:0];
         default: cur_k = 2'd0;
      endcase
      cur_eor   = 32'(byte_in_row_ff) + 32'd1 >= 32'(row_bytes);
      cur_eoi   = cur_eor && (32'(row_ff) + 32'd1 >= 32'(eff_height));
      cur_alpha = (eff_chan == 3'd3) && (cur_k == 2'd2);
   end

   // front state next values
   always_comb begin
      await_in         = await_ff;
      error_latched_in = error_latched_ff;
      filter_in        = filter_ff;
      byte_in_row_in   = byte_in_row_ff;
      mod3_in          = mod3_ff;
      row_in           = row_ff;
      if (accept && !error_latched_ff) begin
         if (await_ff) begin
            if (bad_filter) begin
               error_latched_in = 1'b1;
            end else begin
               filter_in      = req_tdata[2:0];
               await_in       = 1'b0;
               byte_in_row_in = '0;
               mod3_in        = '0;
            end
         end else if (cur_eor) begin
            await_in       = 1'b1;
            byte_in_row_in = '0;
            mod3_in        = '0;
            row_in         = cur_eoi ? '0 : row_ff + ROW_W'(1);
         end else begin
            byte_in_row_in = byte_in_row_ff + BYTE_W'(1);
            mod3_in        = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff         <= 1'b1;
         error_latched_ff <= 1'b0;
         filter_ff        <= png_unf_pkg::FILT_NONE;
         byte_in_row_ff   <= '0;
         mod3_ff          <= '0;
         row_ff           <= '0;
      end else begin
         await_ff         <= await_in;
         error_latched_ff <= error_latched_in;
         filter_ff        <= filter_in;
         byte_in_row_ff   <= byte_in_row_in;
         mod3_ff          <= mod3_in;
         row_ff           <= row_in;
      end
   end

   // stage register control
   assign a_valid_in = (load_err || load_data) ? 1'b1 : (commit ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // stage register payload
   always_ff @(posedge clock) begin
      if (load_err || load_data) begin
         a_err_ff    <= load_err;
         a_raw_ff    <= req_tdata;
         a_idx_ff    <= byte_in_row_ff;
         a_k_ff      <= cur_k;
         a_filter_ff <= filter_ff;
         a_row0_ff   <= row_ff == '0;
         a_eor_ff    <= cur_eor;
         a_eoi_ff    <= cur_eoi;
         a_alpha_ff  <= cur_alpha;
      end
   end

   // line store holding the previous row
   logic [7:0] line_mem [STORE_DEPTH];
   logic [7:0] mem_rd_ff;
   logic       fwd_hit_ff;
   logic [7:0] fwd_byte_ff;
   logic [7:0] recon;

   always_ff @(posedge clock) begin
      if (commit_data) begin
         line_mem[a_idx_ff] <= recon;
      end
   end

   always_ff @(posedge clock) begin
      if (load_data) begin
         mem_rd_ff <= line_mem[byte_in_row_ff];
      end
   end

   // bypass when the byte above is written in the same cycle it is read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (load_data) begin
         fwd_hit_ff <= commit_data && (a_idx_ff == byte_in_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load_data) begin
         fwd_byte_ff <= recon;
      end
   end

   logic [7:0] above;
   assign above = a_row0_ff ? 8'd0 : (fwd_hit_ff ? fwd_byte_ff : mem_rd_ff);

   // chain of channel cells
   png_unf_pkg::nbr_type      chain [NC+1];
   png_unf_pkg::cell_ctl_type cell_ctl;

   assign chain[0]     = '0;
   assign cell_ctl.wr  = commit_data;
   assign cell_ctl.clr = commit_data && a_eor_ff;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      png_unf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .sel       (a_k_ff == 2'(i)),
         .ctl       (cell_ctl),
         .recon     (recon),
         .above     (above),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   // prediction and reconstruction
   logic [7:0] pred;

   always_comb begin
      unique case (a_filter_ff)
         png_unf_pkg::FILT_SUB:   pred = chain[NC].left;
         png_unf_pkg::FILT_UP:    pred = above;
         png_unf_pkg::FILT_AVG:   pred = png_unf_pkg::avg_pick(chain[NC].left, above);
         png_unf_pkg::FILT_PAETH: pred = png_unf_pkg::paeth_pick(chain[NC].left, above,
                                                                  chain[NC].ul);
         default:                 pred = 8'd0;
      endcase
      recon = a_raw_ff + pred;
   end

   // result items
   png_unf_pkg::rsp_type res_first;
   png_unf_pkg::rsp_type res_second;
   png_unf_pkg::rsp_type rsp_item;

   always_comb begin
      if (a_err_ff) begin
         res_first.out_byte     = 8'd0;
         res_first.last_of_run  = 1'b1;
         res_first.end_of_row   = 1'b0;
         res_first.end_of_image = 1'b0;
         res_first.filter_error = 1'b1;
      end else begin
         res_first.out_byte     = recon;
         res_first.last_of_run  = !a_alpha_ff;
         res_first.end_of_row   = !a_alpha_ff && a_eor_ff;
         res_first.end_of_image = !a_alpha_ff && a_eoi_ff;
         res_first.filter_error = 1'b0;
      end
      res_second.out_byte     = png_unf_pkg::ALPHA_BYTE;
      res_second.last_of_run  = 1'b1;
      res_second.end_of_row   = a_eor_ff;
      res_second.end_of_image = a_eoi_ff;
      res_second.filter_error = 1'b0;
   end

   png_unf_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push_en     (commit),
      .push_two    (commit_data && a_alpha_ff),
      .push_first  (res_first),
      .push_second (res_second),
      .room        (oq_room),
      .out_valid   (rsp_tvalid),
      .out_item    (rsp_item),
      .out_ready   (rsp_tready)
   );

   assign rsp_tdata = rsp_item.out_byte;
   assign rsp_tlast = rsp_item.last_of_run;
   assign rsp_tuser = {rsp_item.filter_error, rsp_item.end_of_image, rsp_item.end_of_row};

   // checks
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_latched_ff |=> error_latched_ff)
      else $error("filter error flag dropped without reset");

   a_no_data_after_error: assert property (@(posedge clock) disable iff (reset)
      error_latched_ff |-> !load_data && !load_err)
      else $error("item loaded after filter error");

   a_error_item_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast && rsp_tdata == 8'd0 && rsp_tuser[1:0] == 2'd0)
      else $error("malformed filter error item");

   a_image_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tlast)
      else $error("image end without row end");

endmodule
